>>> rtl/core/qrs_pkg.sv
// Package for the quadratic root solver: widths, root kind codes and shared types.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
    localparam int COEF_W       = 16;
    localparam int OUT_W        = 40;
    localparam int KIND_W       = 3;
    localparam int FRAC_BITS_DF = 16;
    localparam int DISC_W       = 36;  // |b*b - 4ac| < 2^33, kept unsigned with three spare bits
    localparam int INT_STEPS    = 18;  // bit pairs in the discriminant

    typedef enum logic [KIND_W-1:0] {
        KIND_INVALID = 3'd0,
        KIND_LINEAR  = 3'd1,
        KIND_TWO     = 3'd2,
        KIND_DOUBLE  = 3'd3,
        KIND_COMPLEX = 3'd4
    } kind_t;
endpackage
`default_nettype wire

>>> rtl/core/qrs_sqrt_cell.sv
// One bit-pair step of the restoring square root; a row of these forms the root pipeline.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell
    import qrs_pkg::*;
#(
    parameter int RW = 40,   // root width
    parameter int SW = 24,   // sideband width
    parameter int PW = 72    // pending radicand bits
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vin,
    input  wire logic [RW+1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    input  wire logic [PW-1:0] pend_in,
    input  wire logic [SW-1:0] side_in,
    output logic               vout,
    output logic [RW+1:0]      rem_out,
    output logic [RW-1:0]      root_out,
    output logic [PW-1:0]      pend_out,
    output logic [SW-1:0]      side_out
);
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW+1:0] rem_next;
    logic [RW-1:0] root_next;
    logic          v_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [PW-1:0] pend_reg;
    logic [SW-1:0] side_reg;

    always_comb
    begin
        rem_sh = {rem_in[RW-1:0], pend_in[PW-1 -: 2]};
        trial  = {root_in, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[RW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_in[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pend_reg <= {pend_in[PW-3:0], 2'b00};
            side_reg <= side_in;
        end
    end

    assign vout     = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign pend_out = pend_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

>>> rtl/core/qrs_div_cell.sv
// One quotient-bit step of a restoring divider; a row of these forms the divide pipeline.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell
    import qrs_pkg::*;
#(
    parameter int NW = 56,   // dividend / quotient width
    parameter int DW = 17,   // divisor width
    parameter int SW = 8
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vin,
    input  wire logic [DW:0]   rem_in,
    input  wire logic [NW-1:0] quo_in,   // remaining dividend bits shift out, quotient shifts in
    input  wire logic [DW-1:0] den_in,
    input  wire logic [SW-1:0] side_in,
    output logic               vout,
    output logic [DW:0]        rem_out,
    output logic [NW-1:0]      quo_out,
    output logic [DW-1:0]      den_out,
    output logic [SW-1:0]      side_out
);
    logic [DW+1:0] rem_sh;
    logic [DW+1:0] rem_diff;
    logic [DW:0]   rem_next;
    logic          qbit;
    logic          v_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] side_reg;

    always_comb
    begin
        rem_sh   = {rem_in, quo_in[NW-1]};
        rem_diff = rem_sh - {2'b00, den_in};
        qbit     = (rem_sh >= {2'b00, den_in});
        if (qbit)
            rem_next = rem_diff[DW:0];
        else
            rem_next = rem_sh[DW:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_in[NW-2:0], qbit};
            den_reg  <= den_in;
            side_reg <= side_in;
        end
    end

    assign vout     = v_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign den_out  = den_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

>>> rtl/core/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: front end, square root row, divider rows, output.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
`timescale 1ns / 1ps
`default_nettype none
// Solves a*x^2 + b*x + c = 0 for 16-bit signed coefficients and returns the root kind with
// two signed Q(40-FRAC_BITS).FRAC_BITS values, each rounded to nearest with halves away from
// zero. The block is a fully pipelined chain of cells: two register stages form the
// discriminant (both products in the first, the difference in the second), a row of
// 18+FRAC_BITS square root cells retires one root bit per cell, and two parallel rows of
// divider cells retire one quotient bit each, QW = 20 + FRAC_BITS being the quotient width.
// A register stage rounds the root between the root and divider rows, and an output register
// ends the chain. It accepts one transaction per clock cycle while the output is not stalled.
// The whole chain advances only when the output register is free or being drained, so a
// stalled output holds every stage in place.
module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DF
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [COEF_W-1:0] coef_a,
    input  wire logic signed [COEF_W-1:0] coef_b,
    input  wire logic signed [COEF_W-1:0] coef_c,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [KIND_W-1:0]             root_kind,
    output logic signed [OUT_W-1:0]       first_value,
    output logic signed [OUT_W-1:0]       second_value
);
    localparam int SQ_STEPS = INT_STEPS + FRAC_BITS;
    localparam int RW       = SQ_STEPS + 1;            // root incl. rounding carry
    localparam int PW       = 2 * SQ_STEPS;            // radicand scaled by 4^FRAC_BITS
    localparam int NW       = COEF_W + 2 + FRAC_BITS + 2; // |numerator| and quotient
    localparam int DW       = COEF_W + 1;              // |divisor| up to 2^16 (|2a|)
    localparam int SSW      = KIND_W + 2 * NW + DW + 2;

    // advance the whole chain when the output register can take a transaction
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---- stage 1: products
    logic                   s1_v_reg;
    logic signed [33:0]     bb_reg;
    logic signed [33:0]     ac4_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg  <= 34'(coef_b * coef_b);
            ac4_reg <= 34'(coef_a * coef_c) <<< 2;
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            c1_reg  <= coef_c;
        end
    end

    // ---- stage 2: discriminant, kind, numerators prepared
    logic signed [35:0] disc;
    logic               s2_v_reg;
    logic [KIND_W-1:0]  kind_next, kind2_reg;
    logic [DISC_W-1:0]  rad_next, rad2_reg;
    logic signed [NW-1:0] nb_next, nb2_reg;   // -b*one or -c*one
    logic signed [DW:0]   den_next, den2_reg;  // 2a or b

    always_comb
    begin
        disc = 36'(bb_reg) - 36'(ac4_reg);
        rad_next = '0;
        if (a1_reg == '0)
        begin
            kind_next = (b1_reg == '0) ? KIND_INVALID : KIND_LINEAR;
            nb_next   = -(NW'(c1_reg) <<< FRAC_BITS);
            den_next  = (DW+1)'(b1_reg);
        end
        else
        begin
            nb_next  = -(NW'(b1_reg) <<< FRAC_BITS);
            den_next = (DW+1)'(a1_reg) <<< 1;
            if (disc > 0)
            begin
                kind_next = KIND_TWO;
                rad_next  = DISC_W'(disc);
            end
            else if (disc == 0)
                kind_next = KIND_DOUBLE;
            else
            begin
                kind_next = KIND_COMPLEX;
                rad_next  = DISC_W'(-disc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind2_reg <= kind_next;
            rad2_reg  <= rad_next;
            nb2_reg   <= nb_next;
            den2_reg  <= den_next;
        end
    end

    // ---- square root row
    logic [SQ_STEPS:0]         sv;
    logic [RW+1:0]             srem [SQ_STEPS+1];
    logic [RW-1:0]             sroot[SQ_STEPS+1];
    logic [PW-1:0]             spend[SQ_STEPS+1];
    logic [SSW-1:0]            sside[SQ_STEPS+1];

    assign sv[0]    = s2_v_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign spend[0] = {rad2_reg, (PW-DISC_W)'(0)};
    assign sside[0] = {kind2_reg, nb2_reg, NW'(0), den2_reg[DW-1:0], den2_reg[DW], 1'b0};

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sq
        qrs_sqrt_cell #(.RW(RW), .SW(SSW), .PW(PW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(sv[g]), .rem_in(srem[g]), .root_in(sroot[g]),
            .pend_in(spend[g]), .side_in(sside[g]),
            .vout(sv[g+1]), .rem_out(srem[g+1]), .root_out(sroot[g+1]),
            .pend_out(spend[g+1]), .side_out(sside[g+1])
        );
    end

    // ---- stage: round root, form both dividends' magnitudes and signs
    logic [RW-1:0]       s_round;
    logic [KIND_W-1:0]   kq;
    logic signed [NW-1:0] nbq;
    logic [DW-1:0]       dmag_raw;
    logic                dneg;
    logic signed [NW-1:0] n1, n2;
    logic [DW-1:0]       dmag;
    logic                dsign;
    logic                p_v_reg;
    logic [NW-1:0]       m1_reg, m2_reg;
    logic                neg1_reg, neg2_reg;
    logic [DW-1:0]       dv_reg;
    logic [KIND_W-1:0]   kp_reg;

    always_comb
    begin
        kq       = sside[SQ_STEPS][SSW-1 -: KIND_W];
        nbq      = sside[SQ_STEPS][SSW-KIND_W-1 -: NW];
        dmag_raw = sside[SQ_STEPS][DW+1:2];
        dneg     = sside[SQ_STEPS][1];
        s_round  = sroot[SQ_STEPS] + RW'(srem[SQ_STEPS] > (RW+2)'(sroot[SQ_STEPS]));
        // signed divisor value is {dneg,dmag_raw}; take magnitude
        dsign = dneg;
        dmag  = dneg ? DW'(-{dneg, dmag_raw}) : dmag_raw;
        n1 = nbq;
        n2 = nbq;
        if (kq == KIND_TWO)
        begin
            n1 = nbq + NW'(s_round);
            n2 = nbq - NW'(s_round);
        end
        else if (kq == KIND_COMPLEX)
        begin
            n2    = NW'(s_round);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else if (en)
            p_v_reg <= sv[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kp_reg   <= kq;
            dv_reg   <= (dmag == '0) ? DW'(1) : dmag;
            m1_reg   <= (n1 < 0) ? NW'(-n1) : NW'(n1);
            m2_reg   <= (n2 < 0) ? NW'(-n2) : NW'(n2);
            neg1_reg <= (n1 < 0) != dsign;
            neg2_reg <= (kq == KIND_COMPLEX) ? 1'b0 : ((n2 < 0) != dsign);
        end
    end

    // ---- divider rows: divide (m + floor(d/2)) by d
    localparam int DSW = KIND_W + 2;
    logic [NW:0]    dv1, dv2;
    logic [DW:0]    r1 [NW+1];
    logic [DW:0]    r2 [NW+1];
    logic [NW-1:0]  q1 [NW+1];
    logic [NW-1:0]  q2 [NW+1];
    logic [DW-1:0]  dd1[NW+1];
    logic [DW-1:0]  dd2[NW+1];
    logic [DSW-1:0] ds1[NW+1];
    logic [DSW-1:0] ds2[NW+1];

    assign dv1[0] = p_v_reg;
    assign dv2[0] = p_v_reg;
    assign r1[0]  = '0;
    assign r2[0]  = '0;
    assign q1[0]  = m1_reg + NW'(dv_reg >> 1);
    assign q2[0]  = m2_reg + NW'(dv_reg >> 1);
    assign dd1[0] = dv_reg;
    assign dd2[0] = dv_reg;
    assign ds1[0] = {kp_reg, neg1_reg, neg2_reg};
    assign ds2[0] = {kp_reg, neg1_reg, neg2_reg};

    for (genvar g = 0; g < NW; g++)
    begin : g_dv
        qrs_div_cell #(.NW(NW), .DW(DW), .SW(DSW)) u_d1 (
            .clk(clk), .rst_n(rst_n), .en(en), .vin(dv1[g]),
            .rem_in(r1[g]), .quo_in(q1[g]), .den_in(dd1[g]), .side_in(ds1[g]),
            .vout(dv1[g+1]), .rem_out(r1[g+1]), .quo_out(q1[g+1]),
            .den_out(dd1[g+1]), .side_out(ds1[g+1])
        );
        qrs_div_cell #(.NW(NW), .DW(DW), .SW(DSW)) u_d2 (
            .clk(clk), .rst_n(rst_n), .en(en), .vin(dv2[g]),
            .rem_in(r2[g]), .quo_in(q2[g]), .den_in(dd2[g]), .side_in(ds2[g]),
            .vout(dv2[g+1]), .rem_out(r2[g+1]), .quo_out(q2[g+1]),
            .den_out(dd2[g+1]), .side_out(ds2[g+1])
        );
    end

    // ---- output register: apply signs, drop unused values
    logic [KIND_W-1:0]    kf;
    logic signed [OUT_W-1:0] v1_next, v2_next;
    logic                 ov_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic signed [OUT_W-1:0] v1_reg, v2_reg;

    always_comb
    begin
        kf      = ds1[NW][DSW-1 -: KIND_W];
        v1_next = ds1[NW][1] ? -OUT_W'(q1[NW]) : OUT_W'(q1[NW]);
        v2_next = ds1[NW][0] ? -OUT_W'(q2[NW]) : OUT_W'(q2[NW]);
        unique case (kf)
            KIND_INVALID:
            begin
                v1_next = '0;
                v2_next = '0;
            end
            KIND_LINEAR:  v2_next = '0;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv1[NW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= kf;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
        end
    end

    assign out_valid    = ov_reg;
    assign root_kind    = kind_reg;
    assign first_value  = v1_reg;
    assign second_value = v2_reg;

`ifndef SYNTHESIS
    // a stalled output holds the chain, so nothing is taken in meanwhile
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");
    // the two divider rows move in lockstep
    a_rows_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dv1[NW] == dv2[NW])
        else $error("divider rows out of step");
    // second value is zero for invalid and linear kinds
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (root_kind == KIND_INVALID || root_kind == KIND_LINEAR))
            |-> second_value == '0)
        else $error("unused second value not zero");
    // imaginary magnitude never negative
    a_imag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_kind == KIND_COMPLEX) |-> !second_value[OUT_W-1])
        else $error("negative imaginary magnitude");
`endif
endmodule
`default_nettype wire

>>> tb/quadratic_root_solver_unit_test.sv
// Self-checking bench for quadratic_root_solver_unit: directed and random coefficient sets.
// Depends on qrs_pkg and the solver RTL; predicts every result and checks it in order.
`timescale 1ns / 1ps
module quadratic_root_solver_unit_test;
    import qrs_pkg::*;

    localparam int FRAC = FRAC_BITS_DF;
    localparam longint signed VAL_MAX = 64'sd549755813887;
    localparam longint signed VAL_MIN = -64'sd549755813888;
    // Well beyond the fixed pipeline depth of seventy-four stages
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [OUT_W-1:0] first;
        logic signed [OUT_W-1:0] second;
    } roots_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic                     out_valid;
    logic                     out_ready;
    logic [KIND_W-1:0]        root_kind;
    logic signed [OUT_W-1:0]  first_value;
    logic signed [OUT_W-1:0]  second_value;

    roots_t pending_roots[$];
    int     error_count;
    int     sent_count;
    int     checked_count;
    int     kind_seen[5];
    bit     tx_idle_on;
    bit     rx_idle_on;
    int     rx_hold_request;

    quadratic_root_solver_unit #(.FRAC_BITS(FRAC)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coef_a       (coef_a),
        .coef_b       (coef_b),
        .coef_c       (coef_c),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .root_kind    (root_kind),
        .first_value  (first_value),
        .second_value (second_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Root of d scaled by 2^FRAC, one bit per step, then rounded to nearest
    function automatic longint unsigned scaled_sqrt(input longint unsigned d);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned trial;
        rem  = 0;
        root = 0;
        for (int i = 17; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((d >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        for (int i = 0; i < FRAC; i++)
        begin
            rem   = rem << 2;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        if (rem > root)
            root = root + 1;
        return root;
    endfunction

    // Quotient rounded to nearest, halves away from zero
    function automatic longint signed nearest_quotient(input longint signed num,
                                                       input longint signed den);
        bit              neg;
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        q   = (n + d / 2) / d;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_value(input longint signed v);
        if (v > VAL_MAX)
            v = VAL_MAX;
        if (v < VAL_MIN)
            v = VAL_MIN;
        return v[OUT_W-1:0];
    endfunction

    function automatic roots_t solve_quadratic(input logic signed [COEF_W-1:0] ca,
                                               input logic signed [COEF_W-1:0] cb,
                                               input logic signed [COEF_W-1:0] cc);
        longint signed a;
        longint signed b;
        longint signed c;
        longint signed disc;
        longint signed nb;
        longint signed two_a;
        longint signed s;
        longint signed v1;
        longint signed v2;
        kind_t         kind;
        roots_t        r;
        a    = ca;
        b    = cb;
        c    = cc;
        v1   = 0;
        v2   = 0;
        kind = KIND_INVALID;
        if (a == 0)
        begin
            if (b != 0)
            begin
                kind = KIND_LINEAR;
                v1   = nearest_quotient(-c * (64'sd1 <<< FRAC), b);
            end
        end
        else
        begin
            disc  = b * b - 4 * a * c;
            two_a = 2 * a;
            nb    = -b * (64'sd1 <<< FRAC);
            if (disc > 0)
            begin
                kind = KIND_TWO;
                s    = scaled_sqrt(disc);
                v1   = nearest_quotient(nb + s, two_a);
                v2   = nearest_quotient(nb - s, two_a);
            end
            else if (disc == 0)
            begin
                kind = KIND_DOUBLE;
                v1   = nearest_quotient(nb, two_a);
                v2   = v1;
            end
            else
            begin
                kind = KIND_COMPLEX;
                s    = scaled_sqrt(-disc);
                v1   = nearest_quotient(nb, two_a);
                v2   = nearest_quotient(s, (two_a < 0) ? -two_a : two_a);
            end
        end
        r.kind   = kind;
        r.first  = clamp_value(v1);
        r.second = clamp_value(v2);
        return r;
    endfunction

    // Offer one coefficient set; hold valid and payload until the transaction is taken.
    // Valid stays high afterwards unless an idle gap is drawn, so back-to-back sets need no extra edge.
    task automatic send_coefs(input logic signed [COEF_W-1:0] a,
                              input logic signed [COEF_W-1:0] b,
                              input logic signed [COEF_W-1:0] c);
        in_valid <= 1'b1;
        coef_a   <= a;
        coef_b   <= b;
        coef_c   <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_roots.push_back(solve_quadratic(a, b, c));
        sent_count++;
        if (tx_idle_on && ($urandom_range(0, 5) == 0))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    // Equation with a double root at r, scaled by k
    task automatic send_double_root(input int k, input int r);
        send_coefs(COEF_W'(k), COEF_W'(-2 * k * r), COEF_W'(k * r * r));
    endtask

    task automatic test_directed();
        send_coefs(0, 0, 0);                 // invalid, c zero
        send_coefs(0, 0, -32768);            // invalid, c nonzero
        send_coefs(0, 1, 32767);             // linear
        send_coefs(0, -1, -32768);
        send_coefs(0, -32768, 32767);
        send_coefs(0, 3, 1);                 // linear with a rounded quotient
        send_coefs(0, 32767, -32768);
        send_coefs(1, -3, 2);                // two real roots
        send_coefs(-32768, 32767, 32767);
        send_coefs(32767, -32768, -32768);
        send_coefs(1, 0, -32768);
        send_double_root(1, 1);              // double roots
        send_double_root(-3, 5);
        send_coefs(1, 0, 0);
        send_coefs(1, 2, 1);
        send_coefs(1, 0, 1);                 // complex pairs
        send_coefs(-32768, -32768, -32768);
        send_coefs(32767, 32767, 32767);
        send_coefs(-1, 1, -32768);
        send_coefs(32767, 0, 32767);
        send_coefs(-32768, 0, 32767);        // two real roots, wide discriminants
        send_coefs(-32768, -32768, 32767);
    endtask

    task automatic send_random_item();
        int pick;
        int k;
        int r;
        pick = $urandom_range(0, 9);
        case (pick)
            0: send_coefs(0, COEF_W'($urandom), COEF_W'($urandom));
            1: send_coefs(0, 0, COEF_W'($urandom));
            2:
            begin
                k = $urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1);
                r = $urandom_range(0, 20) - 10;
                send_double_root(k, r);
            end
            3: send_coefs(COEF_W'($urandom_range(0, 15) - 8),
                          COEF_W'($urandom_range(0, 31) - 16),
                          COEF_W'($urandom_range(0, 15) - 8));
            default: send_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
        endcase
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_item();
    endtask

    // Stall the output for a long stretch while offering sets back to back,
    // so the pipeline fills and the input stalls
    task automatic test_backpressure();
        tx_idle_on      = 1'b0;
        rx_hold_request = 400;
        repeat (250) send_random_item();
        tx_idle_on      = 1'b1;
    endtask

    // Sender goes quiet until every result is back, then resumes
    task automatic test_pause_and_resume();
        in_valid <= 1'b0;
        wait_all_results();
        @(posedge clk);
        test_random(50);
    endtask

    task automatic test_full_rate(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random(count);
    endtask

    // Receiver: random bursts of stall, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_request) @(posedge clk);
                rx_hold_request = 0;
            end
            else if (rx_idle_on && ($urandom_range(0, 6) == 0))
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_roots.size() == 0)
            begin
                $error("result with nothing expected: kind %0d first %0d second %0d",
                       root_kind, first_value, second_value);
                error_count++;
            end
            else
            begin
                want = pending_roots.pop_front();
                checked_count++;
                if (want.kind <= KIND_COMPLEX)
                    kind_seen[want.kind]++;
                if (root_kind !== want.kind)
                begin
                    $error("root_kind: expected %0d, got %0d", want.kind, root_kind);
                    error_count++;
                end
                if (first_value !== want.first)
                begin
                    $error("first_value: expected %0d, got %0d", want.first, first_value);
                    error_count++;
                end
                if (second_value !== want.second)
                begin
                    $error("second_value: expected %0d, got %0d", want.second,
                           second_value);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("timeout with %0d results outstanding", pending_roots.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        coef_a          = '0;
        coef_b          = '0;
        coef_c          = '0;
        error_count     = 0;
        sent_count      = 0;
        checked_count   = 0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold_request = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random(900);
        test_backpressure();
        test_pause_and_resume();
        test_random(200);
        test_full_rate(330);

        in_valid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_roots.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_roots.size());
            error_count++;
        end

        $display("Sent %0d coefficient sets, checked %0d results", sent_count, checked_count);
        $display("Kinds: invalid %0d linear %0d two %0d double %0d complex %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> quadratic_root_solver_unit.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt_cell.sv
rtl/core/qrs_div_cell.sv
rtl/core/quadratic_root_solver_unit.sv
tb/quadratic_root_solver_unit_test.sv
